FILE: hdl/assert_macros.svh
// assertion macros shared by the heap rtl
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/bhpq_pkg.sv
// shared types and codes of the binary heap priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

   // command codes of a request word
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // error codes of a response word
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   // comparison outcome passed from the rank unit to the sequencer
   typedef struct packed {
      logic pick_right;      // right child ranks above left child
      logic child_over_key;  // chosen child ranks above the moving key
      logic key_over_left;   // moving key ranks above the left operand
   } rank_type;

endpackage

`default_nettype wire

FILE: hdl/binary_heap_priority_queue.sv
// binary heap priority queue: sequencer, order register and response word
// depends on bhpq_pkg, bhpq_key_ram, bhpq_rank and assert_macros.svh
// sequence: clear, reject or a pop that empties goes straight to the response state;
//   push sifts up from the tail (onto an empty heap it places at once), pop loads the old tail and sifts down
// throughput: one word at a time; busy stays high until the response is issued,
//   and the walk takes one memory access and one strict compare per heap level
// reset: synchronous, clears the count, the order mode (min-heap) and the sequencer;
//   key storage is not cleared, only entries below the count are ever used
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module binary_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int HEAP_DEPTH = 64,
   parameter int KEY_WIDTH  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request word
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_command,
   input  wire logic signed [KEY_WIDTH-1:0]         req_key_value,
   // response word, one cycle per strobe, no back-pressure
   output logic                                     rsp_strobe,
   output logic signed [KEY_WIDTH-1:0]              rsp_top_key,
   output logic [$clog2(HEAP_DEPTH+1)-1:0]          rsp_entry_count,
   output logic                                     rsp_is_empty,
   output logic [1:0]                               rsp_error_code,
   // order mode register
   input  wire logic                                csr_write_enable,
   input  wire logic                                csr_write_data
);

   localparam int AW  = $clog2(HEAP_DEPTH);     // slot address width
   localparam int CW  = $clog2(HEAP_DEPTH + 1); // entry count width
   localparam int CIW = AW + 2;                 // child index, holds 2*depth

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_POP_LOAD,
      ST_POP_KEY,
      ST_DOWN_CMP,
      ST_PLACE,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;       // key being sifted
   logic [AW-1:0]               pos_ff, pos_in;       // hole position
   logic [AW-1:0]               kid_ff, kid_in;       // left child in flight
   logic                        right_ok_ff, right_ok_in;
   logic [CW-1:0]               count_ff, count_in;
   logic signed [KEY_WIDTH-1:0] root_ff, root_in;    // shadow of slot zero
   logic [1:0]                  err_ff, err_in;
   logic                        mode_ff, mode_in;

   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic signed [KEY_WIDTH-1:0] rsp_top_key_ff, rsp_top_key_in;
   logic [CW-1:0]               rsp_entry_count_ff, rsp_entry_count_in;
   logic                        rsp_is_empty_ff, rsp_is_empty_in;
   logic [1:0]                  rsp_error_code_ff, rsp_error_code_in;

   // memory port controls
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic signed [KEY_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]               ram_raddr_a;
   logic [AW-1:0]               ram_raddr_b;
   logic signed [KEY_WIDTH-1:0] ram_rdata_a;
   logic signed [KEY_WIDTH-1:0] ram_rdata_b;

   logic signed [KEY_WIDTH-1:0] chosen_key;
   rank_type                    rank;

   logic [AW-1:0]               parent_pos;
   logic [AW-1:0]               chosen_pos;
   logic [AW-1:0]               down_base;
   logic [CIW-1:0]              kid_l;
   logic [CIW-1:0]              kid_r;
   logic                        has_l;
   logic                        has_r;

   bhpq_key_ram #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_key_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_a (ram_rdata_a),
      .rd_data_b (ram_rdata_b)
   );

   // port a carries the parent on the way up and the left child on the way down
   bhpq_rank #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_rank (
      .order_mode (mode_ff),
      .key        (key_ff),
      .left       (ram_rdata_a),
      .right      (ram_rdata_b),
      .right_ok   (right_ok_ff),
      .chosen_key (chosen_key),
      .rank       (rank)
   );

   // slot arithmetic
   always_comb begin
      parent_pos = (pos_ff - AW'(1)) >> 1;
      // a right child is only chosen when it lies below the count, so it fits
      chosen_pos = rank.pick_right ? (kid_ff + AW'(1)) : kid_ff;
      down_base  = (state_ff == ST_DOWN_CMP) ? chosen_pos : '0;
      kid_l      = (CIW'(down_base) << 1) | CIW'(1);
      kid_r      = kid_l + CIW'(1);
      has_l      = kid_l < CIW'(count_ff);
      has_r      = kid_r < CIW'(count_ff);
   end

   // sequencer next state
   always_comb begin
      state_in           = state_ff;
      key_in             = key_ff;
      pos_in             = pos_ff;
      kid_in             = kid_ff;
      right_ok_in        = right_ok_ff;
      count_in           = count_ff;
      err_in             = err_ff;
      mode_in            = csr_write_enable ? csr_write_data : mode_ff;
      rsp_strobe_in      = 1'b0;
      rsp_top_key_in     = rsp_top_key_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_is_empty_in    = rsp_is_empty_ff;
      rsp_error_code_in  = rsp_error_code_ff;
      ram_we             = 1'b0;
      ram_waddr          = pos_ff;
      ram_wdata          = key_ff;
      ram_raddr_a        = kid_l[AW-1:0];
      ram_raddr_b        = kid_r[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_key_value;
               err_in = ERR_OK;
               unique case (req_command)
                  CMD_PUSH: begin
                     if (count_ff == CW'(HEAP_DEPTH)) begin
                        err_in   = ERR_FULL;
                        state_in = ST_DONE;
                     end else begin
                        // hole opens at the tail
                        pos_in   = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                        state_in = (count_ff == '0) ? ST_PLACE : ST_UP_READ;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        err_in   = ERR_EMPTY;
                        state_in = ST_DONE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        state_in = (count_ff == CW'(1)) ? ST_DONE : ST_POP_LOAD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     // unused code: status only
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_UP_READ: begin
            ram_raddr_a = parent_pos;
            state_in    = ST_UP_CMP;
         end
         ST_UP_CMP: begin
            ram_we = 1'b1;
            if (rank.key_over_left) begin
               // parent drops into the hole, fetch the next parent at once
               ram_wdata   = ram_rdata_a;
               pos_in      = parent_pos;
               ram_raddr_a = (parent_pos - AW'(1)) >> 1;
               state_in    = (parent_pos == '0) ? ST_PLACE : ST_UP_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP_LOAD: begin
            // count is already decremented, so it addresses the old tail
            ram_raddr_a = count_ff[AW-1:0];
            state_in    = ST_POP_KEY;
         end
         ST_POP_KEY: begin
            key_in      = ram_rdata_a;
            pos_in      = '0;
            kid_in      = kid_l[AW-1:0];
            right_ok_in = has_r;
            state_in    = has_l ? ST_DOWN_CMP : ST_PLACE;
         end
         ST_DOWN_CMP: begin
            ram_we = 1'b1;
            if (rank.child_over_key) begin
               // better child rises into the hole, children of its slot are read next
               ram_wdata   = chosen_key;
               pos_in      = chosen_pos;
               kid_in      = kid_l[AW-1:0];
               right_ok_in = has_r;
               state_in    = has_l ? ST_DOWN_CMP : ST_PLACE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PLACE: begin
            ram_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe_in      = 1'b1;
            rsp_top_key_in     = (count_ff == '0) ? '0 : root_ff;
            rsp_entry_count_in = count_ff;
            rsp_is_empty_in    = (count_ff == '0);
            rsp_error_code_in  = err_ff;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // keep the root shadow in step with slot zero
      root_in = (ram_we && (ram_waddr == '0)) ? ram_wdata : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         mode_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      key_ff             <= key_in;
      pos_ff             <= pos_in;
      kid_ff             <= kid_in;
      right_ok_ff        <= right_ok_in;
      root_ff            <= root_in;
      err_ff             <= err_in;
      rsp_top_key_ff     <= rsp_top_key_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_is_empty_ff    <= rsp_is_empty_in;
      rsp_error_code_ff  <= rsp_error_code_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_top_key     = rsp_top_key_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_error_code  = rsp_error_code_ff;

   // count never passes the capacity
   `ASSERT_IMPLIES(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(HEAP_DEPTH))
   // storage is only written while a word is in progress
   `ASSERT_IMPLIES(a_write_when_busy, clock, reset, ram_we, busy)
   // the hole stays inside the live part of the heap on the way up
   `ASSERT_IMPLIES(a_up_hole_live, clock, reset, state_ff == ST_UP_CMP,
                   CW'(pos_ff) < count_ff)
   // one strobe per word, never two in a row
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   // empty flag agrees with the reported count
   `ASSERT_IMPLIES(a_empty_matches, clock, reset, rsp_strobe_ff,
                   rsp_is_empty_ff == (rsp_entry_count_ff == '0))

endmodule

`default_nettype wire

FILE: hdl/bhpq_key_ram.sv
// key storage: one write port, two registered read ports
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module bhpq_key_ram #(
   parameter int HEAP_DEPTH = 64,
   parameter int KEY_WIDTH  = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [$clog2(HEAP_DEPTH)-1:0]         wr_addr,
   input  wire logic signed [KEY_WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(HEAP_DEPTH)-1:0]         rd_addr_a,
   input  wire logic [$clog2(HEAP_DEPTH)-1:0]         rd_addr_b,
   output logic signed [KEY_WIDTH-1:0]                rd_data_a,
   output logic signed [KEY_WIDTH-1:0]                rd_data_b
);

   logic signed [KEY_WIDTH-1:0] mem [HEAP_DEPTH];
   logic signed [KEY_WIDTH-1:0] rd_data_a_ff;
   logic signed [KEY_WIDTH-1:0] rd_data_b_ff;

   // read returns the old contents on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

FILE: hdl/bhpq_rank.sv
// rank unit: child selection and strict ordering compares
// depends on bhpq_pkg for rank_type
`timescale 1ns / 1ps
`default_nettype none

module bhpq_rank
   import bhpq_pkg::*;
#(
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                        order_mode,
   input  wire logic signed [KEY_WIDTH-1:0] key,
   input  wire logic signed [KEY_WIDTH-1:0] left,
   input  wire logic signed [KEY_WIDTH-1:0] right,
   input  wire logic                        right_ok,
   output logic signed [KEY_WIDTH-1:0]      chosen_key,
   output rank_type                         rank
);

   logic right_over_left;
   logic chosen_over_key;
   logic key_over_left;

   // strict compare: equal keys never move
   always_comb begin
      right_over_left = order_mode ? (right > left) : (right < left);
      key_over_left   = order_mode ? (key > left) : (key < left);
      chosen_key      = (right_ok && right_over_left) ? right : left;
      chosen_over_key = order_mode ? (chosen_key > key) : (chosen_key < key);
   end

   assign rank.pick_right     = right_ok && right_over_left;
   assign rank.child_over_key = chosen_over_key;
   assign rank.key_over_left  = key_over_left;

endmodule

`default_nettype wire
